// ===== hdl/etc_pkg.sv =====
// etc_pkg: constants shared by the epoch-to-calendar pipeline and its checker
// no dependencies; imported by epoch_seconds_to_calendar, etc_checker and tb_top
`timescale 1ns / 1ps

package etc_pkg;

    // field widths
    localparam int ETC_EPOCH_W = 48;
    localparam int ETC_YEAR_W  = 24;

    // calendar constants
    localparam int ETC_SECS_PER_DAY  = 86400;
    localparam int ETC_SECS_PER_HOUR = 3600;
    localparam int ETC_DAYS_400Y     = 365 * 400 + 97;
    localparam int ETC_DAYS_100Y     = 365 * 100 + 24;
    localparam int ETC_DAYS_4Y       = 365 * 4 + 1;
    localparam int ETC_DAYS_1Y       = 365;
    // days from 1 march back to 1 january in a common year
    localparam int ETC_JAN_TO_MAR    = 31 + 28;

    // seconds from the epoch to 2000-03-01 00:00:00
    localparam longint ETC_MARCH_2000_SECS = 64'sd946684800 + 64'sd86400 * (31 + 29);

    // whole 400-year cycles added so that the shifted time is never negative;
    // a 400-year cycle is a whole number of weeks, so weekdays are unaffected
    localparam longint ETC_BIAS_CYCLES = 64'sd16384;
    localparam longint ETC_EPOCH_BIAS =
        ETC_BIAS_CYCLES * ETC_DAYS_400Y * ETC_SECS_PER_DAY - ETC_MARCH_2000_SECS;

    // years since 1900 of the first counted year, less the bias cycles
    localparam logic [ETC_YEAR_W-1:0] ETC_YEAR_BIAS =
        ETC_YEAR_W'(64'sd100 - 64'sd400 * ETC_BIAS_CYCLES);

    // first day of each month, counted from 1 march
    localparam logic [8:0] ETC_MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // month codes
    localparam logic [3:0] ETC_MON_JAN = 4'd0;
    localparam logic [3:0] ETC_MON_FEB = 4'd1;
    localparam logic [3:0] ETC_MON_DEC = 4'd11;
    // march-based index from which the month falls in the next year
    localparam logic [3:0] ETC_MAR_IDX_JAN = 4'd10;

    // cycles from an accepted start to its done strobe
    localparam int ETC_LATENCY = 18;

endpackage

// ===== hdl/epoch_seconds_to_calendar.sv =====
// epoch_seconds_to_calendar: top level of the seconds-to-calendar pipeline
// depends on etc_pkg and etc_cdiv
`timescale 1ns / 1ps

// Converts a signed 48-bit count of seconds since 1970-01-01 00:00:00 UTC into
// proleptic Gregorian UTC fields: year - 1900, month, day, hour, minute,
// second, weekday (sunday 0) and day of year.
// Input: drive epoch_seconds and raise start; the transfer happens at the
// rising edge where start is high and busy is low. busy is never raised, so
// a new time can be given in every cycle.
// Output: done is high for exactly one cycle with the fields of one result;
// results leave in the order their inputs came. The receiver cannot hold
// results off, and none is needed: nothing inside ever waits.
// Throughput is one conversion per cycle. The pipeline is seven constant
// dividers of two stages each (reciprocal multiply, then correction) plus
// four stages for the bias add, compares, small constant multiplies and the
// month table.
// Reset clears only the valid bits, so no done strobe appears for anything
// in flight at reset; there is no other state and no start-up delay.

module epoch_seconds_to_calendar
    import etc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ETC_EPOCH_W-1:0] epoch_seconds,
    output logic                         done,
    output logic signed [ETC_YEAR_W-1:0] years_since_1900,
    output logic [3:0]                   month_index,
    output logic [4:0]                   day_of_month,
    output logic [4:0]                   hour_of_day,
    output logic [5:0]                   minute_of_hour,
    output logic [5:0]                   second_of_minute,
    output logic [2:0]                   weekday,
    output logic [8:0]                   day_of_year
);

    localparam int U_W = ETC_EPOCH_W + 1;

    typedef struct packed {
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  hour;
        logic [14:0] n400u;
        logic [17:0] rem400;
    } day_sb_t;

    typedef struct packed {
        logic [1:0]            n100;
        logic [ETC_YEAR_W-1:0] yacc;
        logic [2:0]            wday;
        logic [4:0]            hour;
        logic [5:0]            minute;
        logic [5:0]            second;
    } tail_sb_t;

    // biased time, always positive
    logic           v0_reg;
    logic [U_W-1:0] u_reg;

    // day and second split, u / 86400 as (u >> 7) / 675 in two halves
    logic        v1;
    logic [11:0] qh;
    logic [9:0]  rh;
    logic [27:0] sb1;
    logic        v2;
    logic [20:0] q2;
    logic [9:0]  r2;
    logic [18:0] sb2;
    logic [31:0] days_u;
    logic [16:0] sod;

    // 400-year cycles, then time of day
    logic        v3;
    logic [14:0] n400u;
    logic [17:0] rem400;
    logic [16:0] sb3;
    logic        v4;
    logic [4:0]  hour;
    logic [11:0] r3600;
    logic [32:0] sb4;
    logic        v5;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [37:0] sb5;
    logic [17:0] rem400_5;
    logic        v6;
    logic [2:0]  wday;
    day_sb_t     sb6;

    // century step
    logic [1:0]            n100_next;
    logic [17:0]           rem100_full;
    logic [ETC_YEAR_W-1:0] yacc_next;
    logic                  c1_valid_reg;
    logic [15:0]           rem100_reg;
    tail_sb_t              c1_sb_reg;

    // four-year step
    logic     v7;
    logic [4:0]  n4;
    logic [10:0] rem4;
    tail_sb_t    sb7;

    // single year step
    logic [1:0]            n1_next;
    logic [10:0]           rem1_full;
    logic                  leap_next;
    logic                  c3_valid_reg;
    logic [8:0]            rem1_reg;
    logic                  leap_reg;
    logic [ETC_YEAR_W-1:0] yacc_reg;
    tail_sb_t              c3_sb_reg;

    // month step
    logic [3:0]            midx;
    logic [8:0]            rem_m;
    logic [3:0]            mon_next;
    logic [9:0]            yday_full;
    logic [8:0]            yday_next;
    logic [ETC_YEAR_W-1:0] year_next;
    logic                  done_reg;
    logic [ETC_YEAR_W-1:0] year_reg;
    logic [3:0]            mon_reg;
    logic [4:0]            dom_reg;
    logic [8:0]            yday_reg;
    tail_sb_t              out_sb_reg;

    assign busy = 1'b0;

    // input transfer and bias
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            c1_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            v0_reg       <= start && !busy;
            c1_valid_reg <= v6;
            c3_valid_reg <= v7;
            done_reg     <= c3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= {epoch_seconds[ETC_EPOCH_W-1], epoch_seconds} + U_W'(ETC_EPOCH_BIAS);
    end

    // upper half of the day division
    etc_cdiv #(.X_W(21), .DIV(675), .Q_W(12), .SB_W(28)) u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .x         (u_reg[48:28]),
        .sb_in     (u_reg[27:0]),
        .out_valid (v1),
        .q         (qh),
        .r         (rh),
        .sb_out    (sb1)
    );

    // lower half of the day division
    etc_cdiv #(.X_W(31), .DIV(675), .Q_W(21), .SB_W(19)) u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .x         ({rh, sb1[27:7]}),
        .sb_in     ({qh, sb1[6:0]}),
        .out_valid (v2),
        .q         (q2),
        .r         (r2),
        .sb_out    (sb2)
    );

    assign days_u = 32'({sb2[18:7], q2});
    assign sod    = {r2, sb2[6:0]};

    // 400-year cycles
    etc_cdiv #(.X_W(32), .DIV(ETC_DAYS_400Y), .Q_W(15), .SB_W(17)) u_div_400 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .x         (days_u),
        .sb_in     (sod),
        .out_valid (v3),
        .q         (n400u),
        .r         (rem400),
        .sb_out    (sb3)
    );

    // hour of day
    etc_cdiv #(.X_W(17), .DIV(ETC_SECS_PER_HOUR), .Q_W(5), .SB_W(33)) u_div_hour (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .x         (sb3),
        .sb_in     ({n400u, rem400}),
        .out_valid (v4),
        .q         (hour),
        .r         (r3600),
        .sb_out    (sb4)
    );

    // minute and second
    etc_cdiv #(.X_W(12), .DIV(60), .Q_W(6), .SB_W(38)) u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4),
        .x         (r3600),
        .sb_in     ({hour, sb4}),
        .out_valid (v5),
        .q         (minute),
        .r         (second),
        .sb_out    (sb5)
    );

    // weekday: day 0 of each cycle is a wednesday
    assign rem400_5 = sb5[17:0];

    etc_cdiv #(.X_W(18), .DIV(7), .Q_W(15), .SB_W($bits(day_sb_t))) u_div_wday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5),
        .x         (rem400_5 + 18'd3),
        .sb_in     ({minute, second, sb5}),
        .out_valid (v6),
        .q         (),
        .r         (wday),
        .sb_out    (sb6)
    );

    // centuries, clamped so the cycle's last leap day stays in the fourth
    always_comb
    begin
        if (sb6.rem400 >= 18'(3 * ETC_DAYS_100Y))
        begin
            n100_next = 2'd3;
        end
        else if (sb6.rem400 >= 18'(2 * ETC_DAYS_100Y))
        begin
            n100_next = 2'd2;
        end
        else if (sb6.rem400 >= 18'(ETC_DAYS_100Y))
        begin
            n100_next = 2'd1;
        end
        else
        begin
            n100_next = 2'd0;
        end
        rem100_full = sb6.rem400 - 18'(n100_next) * 18'(ETC_DAYS_100Y);
        yacc_next   = ETC_YEAR_W'(sb6.n400u) * ETC_YEAR_W'(400) + ETC_YEAR_BIAS
                      + ETC_YEAR_W'(n100_next) * ETC_YEAR_W'(100);
    end

    always_ff @(posedge clk)
    begin
        rem100_reg       <= rem100_full[15:0];
        c1_sb_reg.n100   <= n100_next;
        c1_sb_reg.yacc   <= yacc_next;
        c1_sb_reg.wday   <= wday;
        c1_sb_reg.hour   <= sb6.hour;
        c1_sb_reg.minute <= sb6.minute;
        c1_sb_reg.second <= sb6.second;
    end

    // four-year cycles; a century holds under 25 of them, so no clamp
    etc_cdiv #(.X_W(16), .DIV(ETC_DAYS_4Y), .Q_W(5), .SB_W($bits(tail_sb_t))) u_div_4y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid_reg),
        .x         (rem100_reg),
        .sb_in     (c1_sb_reg),
        .out_valid (v7),
        .q         (n4),
        .r         (rem4),
        .sb_out    (sb7)
    );

    // single years, clamped so the leap day stays in the fourth year
    always_comb
    begin
        if (rem4 >= 11'(3 * ETC_DAYS_1Y))
        begin
            n1_next = 2'd3;
        end
        else if (rem4 >= 11'(2 * ETC_DAYS_1Y))
        begin
            n1_next = 2'd2;
        end
        else if (rem4 >= 11'(ETC_DAYS_1Y))
        begin
            n1_next = 2'd1;
        end
        else
        begin
            n1_next = 2'd0;
        end
        rem1_full = rem4 - 11'(n1_next) * 11'(ETC_DAYS_1Y);
        // calendar year holding the march that opens the counted year is a leap year
        leap_next = (n1_next == 2'd0) && ((n4 != 5'd0) || (sb7.n100 == 2'd0));
    end

    always_ff @(posedge clk)
    begin
        rem1_reg  <= rem1_full[8:0];
        leap_reg  <= leap_next;
        yacc_reg  <= sb7.yacc + ETC_YEAR_W'(n4) * ETC_YEAR_W'(4) + ETC_YEAR_W'(n1_next);
        c3_sb_reg <= sb7;
    end

    // month table walk, day of year and year roll-over
    always_comb
    begin
        midx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (rem1_reg >= ETC_MONTH_START[k])
            begin
                midx = 4'(k);
            end
        end
        rem_m = rem1_reg - ETC_MONTH_START[midx];
        if (midx >= ETC_MAR_IDX_JAN)
        begin
            mon_next  = midx - ETC_MAR_IDX_JAN;
            year_next = yacc_reg + ETC_YEAR_W'(1);
        end
        else
        begin
            mon_next  = midx + 4'd2;
            year_next = yacc_reg;
        end
        yday_full = 10'(rem1_reg) + 10'(ETC_JAN_TO_MAR) + 10'(leap_reg);
        if (yday_full >= 10'(ETC_DAYS_1Y) + 10'(leap_reg))
        begin
            yday_next = 9'(yday_full - 10'(ETC_DAYS_1Y) - 10'(leap_reg));
        end
        else
        begin
            yday_next = yday_full[8:0];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        dom_reg    <= 5'(rem_m + 9'd1);
        yday_reg   <= yday_next;
        out_sb_reg <= c3_sb_reg;
    end

    assign done             = done_reg;
    assign years_since_1900 = year_reg;
    assign month_index      = mon_reg;
    assign day_of_month     = dom_reg;
    assign hour_of_day      = out_sb_reg.hour;
    assign minute_of_hour   = out_sb_reg.minute;
    assign second_of_minute = out_sb_reg.second;
    assign weekday          = out_sb_reg.wday;
    assign day_of_year      = yday_reg;

endmodule

// ===== hdl/etc_cdiv.sv =====
// etc_cdiv: two-stage pipelined divider by a constant, with sideband
// reciprocal multiply then one correction step; no package dependency
`timescale 1ns / 1ps

module etc_cdiv #(
    parameter int X_W  = 16,
    parameter int DIV  = 10,
    parameter int Q_W  = 16,
    parameter int SB_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [X_W-1:0]           x,
    input  logic [SB_W-1:0]          sb_in,
    output logic                     out_valid,
    output logic [Q_W-1:0]           q,
    output logic [$clog2(DIV)-1:0]   r,
    output logic [SB_W-1:0]          sb_out
);

    localparam int R_W = $clog2(DIV);
    localparam int M_W = X_W - R_W + 1;
    localparam int P_W = X_W + M_W;
    // floor(2^X_W / DIV): the estimate is the quotient or one below it
    localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << X_W) / DIV);

    logic [P_W-1:0]  prod_a;
    logic [M_W-1:0]  q_est;
    logic            va_reg;
    logic [X_W-1:0]  xa_reg;
    logic [M_W-1:0]  qa_reg;
    logic [SB_W-1:0] sba_reg;

    logic [X_W-1:0]  r_full;
    logic            fix;
    logic [Q_W-1:0]  q_next;
    logic [R_W-1:0]  r_next;
    logic            vb_reg;
    logic [Q_W-1:0]  q_reg;
    logic [R_W-1:0]  r_reg;
    logic [SB_W-1:0] sbb_reg;

    // quotient estimate
    assign prod_a = P_W'(x) * P_W'(RECIP);
    assign q_est  = prod_a[P_W-1:X_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg  <= x;
        qa_reg  <= q_est;
        sba_reg <= sb_in;
        q_reg   <= q_next;
        r_reg   <= r_next;
        sbb_reg <= sba_reg;
    end

    // remainder and correction
    always_comb
    begin
        r_full = xa_reg - X_W'(qa_reg) * X_W'(DIV);
        fix    = (r_full >= X_W'(DIV));
        q_next = Q_W'(qa_reg + M_W'(fix));
        r_next = fix ? R_W'(r_full - X_W'(DIV)) : R_W'(r_full);
    end

    assign out_valid = vb_reg;
    assign q         = q_reg;
    assign r         = r_reg;
    assign sb_out    = sbb_reg;

endmodule

// ===== hdl/etc_checker.sv =====
// etc_checker: port-level assertions for epoch_seconds_to_calendar, and its bind
// depends on etc_pkg
`timescale 1ns / 1ps

module etc_checker
    import etc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] month_index,
    input logic [4:0] day_of_month,
    input logic [4:0] hour_of_day,
    input logic [5:0] minute_of_hour,
    input logic [5:0] second_of_minute,
    input logic [2:0] weekday,
    input logic [8:0] day_of_year
);

    // every input transfer gives a result after the pipeline latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##ETC_LATENCY done)
        else $error("transfer without a result after the pipeline latency");

    // no result without a transfer the pipeline latency earlier
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ETC_LATENCY))
        else $error("result without a matching input transfer");

    // fields in range
    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> month_index <= ETC_MON_DEC && day_of_month != 5'd0
            && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59
            && second_of_minute <= 6'd59 && weekday <= 3'd6)
        else $error("calendar field out of range");

    // january day of year follows the day of month, february has no 30th
    a_month_days: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month_index != ETC_MON_JAN || day_of_year == 9'(day_of_month) - 9'd1)
            && (month_index != ETC_MON_FEB || day_of_month <= 5'd29))
        else $error("day of month inconsistent with month");

endmodule

bind epoch_seconds_to_calendar etc_checker u_etc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .weekday          (weekday),
    .day_of_year      (day_of_year)
);

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for the epoch seconds to calendar pipeline
// holds its own calendar predictor and scoreboard; needs etc_pkg and the rtl
`timescale 1ns / 1ps

// calendar fields of one conversion, at the widths of the result ports
typedef struct packed {
    logic signed [23:0] years;
    logic [3:0]         month;
    logic [4:0]         mday;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [2:0]         wday;
    logic [8:0]         yday;
} calendar_t;

class calendar_scoreboard;

    // seconds from the epoch to 2000-03-01, start of the counted years
    localparam longint MARCH_2000 = 64'sd951868800;
    localparam longint DAY_SECS   = 64'sd86400;
    localparam longint CYCLE_400  = 64'sd146097;
    localparam longint CYCLE_100  = 64'sd36524;
    localparam longint CYCLE_4    = 64'sd1461;
    localparam int     MAX_LINES  = 40;

    calendar_t          pending_dates [$];
    logic [47:0]        pending_secs [$];
    int                 errors;
    // month lengths counted from march
    int                 month_days [12] = '{31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 29};

    function new();
        errors = 0;
    endfunction

    function longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) < 0)
            q = q - 1;
        return q;
    endfunction

    function longint floor_rem(longint a, longint b);
        longint r;
        r = a % b;
        if (r < 0)
            r = r + b;
        return r;
    endfunction

    // proleptic gregorian breakdown of one signed 48-bit time
    function calendar_t to_calendar(logic [47:0] secs);
        calendar_t c;
        longint    t, s, days, sod, rem, n400, n100, n4, n1, leap, yday, year, mon;
        int        m;
        t    = $signed(secs);
        s    = t - MARCH_2000;
        days = floor_quot(s, DAY_SECS);
        sod  = floor_rem(s, DAY_SECS);
        n400 = floor_quot(days, CYCLE_400);
        rem  = floor_rem(days, CYCLE_400);
        // last day of a 400-year cycle stays in the final century
        n100 = rem / CYCLE_100;
        if (n100 == 4)
            n100 = 3;
        rem = rem - n100 * CYCLE_100;
        n4 = rem / CYCLE_4;
        if (n4 == 25)
            n4 = 24;
        rem = rem - n4 * CYCLE_4;
        // last day of a 4-year cycle stays in the final year
        n1 = rem / 365;
        if (n1 == 4)
            n1 = 3;
        rem  = rem - n1 * 365;
        leap = (n1 == 0 && (n4 != 0 || n100 == 0)) ? 1 : 0;
        yday = rem + 59 + leap;
        if (yday >= 365 + leap)
            yday = yday - (365 + leap);
        year = n1 + 4 * n4 + 100 * n100 + 400 * n400 + 100;
        // walk the march-based month table
        m = 0;
        while (m < 11 && month_days[m] <= rem)
        begin
            rem = rem - month_days[m];
            m++;
        end
        mon = m + 2;
        if (mon >= 12)
        begin
            mon  = mon - 12;
            year = year + 1;
        end
        c.years  = year[23:0];
        c.month  = mon[3:0];
        c.mday   = 5'(rem + 1);
        c.hour   = 5'(sod / 3600);
        c.minute = 6'((sod / 60) % 60);
        c.second = 6'(sod % 60);
        c.wday   = 3'(floor_rem(days + 3, 7));
        c.yday   = yday[8:0];
        return c;
    endfunction

    function void note_input(logic [47:0] secs);
        pending_dates.push_back(to_calendar(secs));
        pending_secs.push_back(secs);
    endfunction

    function int pending();
        return pending_dates.size();
    endfunction

    task report(string msg);
        if (errors < MAX_LINES)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task compare_field(string name, longint got, longint want, logic [47:0] secs);
        if (got != want)
            report($sformatf("%s got %0d expected %0d for time %0d",
                             name, got, want, $signed(secs)));
    endtask

    task check_result(calendar_t got);
        calendar_t   want;
        logic [47:0] secs;
        if (pending_dates.size() == 0)
        begin
            report("result with no conversion outstanding");
            return;
        end
        want = pending_dates.pop_front();
        secs = pending_secs.pop_front();
        compare_field("years_since_1900", got.years, want.years, secs);
        compare_field("month_index", got.month, want.month, secs);
        compare_field("day_of_month", got.mday, want.mday, secs);
        compare_field("hour_of_day", got.hour, want.hour, secs);
        compare_field("minute_of_hour", got.minute, want.minute, secs);
        compare_field("second_of_minute", got.second, want.second, secs);
        compare_field("weekday", got.wday, want.wday, secs);
        compare_field("day_of_year", got.yday, want.yday, secs);
    endtask

endclass

module tb_top
    import etc_pkg::*;
();

    localparam int     HALF_PERIOD    = 6;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PHASE_ITEMS    = 360;
    localparam longint MARCH_2000     = 64'sd951868800;

    // extremes, day and cycle boundaries, leap days and dates before the epoch
    localparam longint DIRECTED_TIMES [23] = '{
        64'sd0, -64'sd1, 64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
        64'sd140737488355327, -64'sd140737488355328,
        64'sh0000_AAAA_AAAA_AAAA, 64'sh0000_5555_5555_5555,
        64'sd946684799, 64'sd951868799, 64'sd951868800, 64'sd978220800,
        64'sd1078012800, 64'sd1078099199, 64'sd4107628799, 64'sd4107628800,
        64'sd13574563200, 64'sd13574649599, -64'sd2208988800, -64'sd2208988801
    };

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [ETC_EPOCH_W-1:0] epoch_seconds = '0;
    logic                          done;
    logic signed [ETC_YEAR_W-1:0]  years_since_1900;
    logic [3:0]                    month_index;
    logic [4:0]                    day_of_month;
    logic [4:0]                    hour_of_day;
    logic [5:0]                    minute_of_hour;
    logic [5:0]                    second_of_minute;
    logic [2:0]                    weekday;
    logic [8:0]                    day_of_year;

    calendar_scoreboard sb = new();
    int                 gap_pct = 30;
    int                 idle_cycles = 0;
    int                 phase;
    int                 k;

    epoch_seconds_to_calendar i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday),
        .day_of_year      (day_of_year)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // one start transfer, with random idle cycles ahead of it
    task send_time(input logic [ETC_EPOCH_W-1:0] secs);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(secs);
    endtask

    // random time: full 48-bit range, within a few thousand years, near cycle ends or near the extremes
    function automatic logic [ETC_EPOCH_W-1:0] random_time();
        logic [63:0] raw;
        longint      day_off;
        longint      secs;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2:
                secs = longint'(raw[47:0]);
            3, 4, 5:
                secs = longint'($signed(raw[36:0]));
            6, 7, 8:
            begin
                day_off = (longint'($urandom_range(0, 20000)) - 10000) * 146097
                        + longint'($urandom_range(0, 4)) * 36524
                        + longint'($urandom_range(0, 25)) * 1461
                        + longint'($urandom_range(0, 4)) * 365
                        + longint'($urandom_range(0, 3)) - 2;
                secs = MARCH_2000 + day_off * 86400 + longint'($urandom_range(0, 86399));
            end
            default:
                if (raw[63])
                    secs = 64'sd140737488355327 - longint'(raw[19:0]);
                else
                    secs = -64'sd140737488355328 + longint'(raw[19:0]);
        endcase
        return ETC_EPOCH_W'(secs);
    endfunction

    // result monitor: each done cycle is one transfer out
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result('{years_since_1900, month_index, day_of_month, hour_of_day,
                              minute_of_hour, second_of_minute, weekday, day_of_year});
    end

    // watchdog on cycles with no transfer either way
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // reset, then directed and random phases
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 23; k++)
            send_time(ETC_EPOCH_W'(DIRECTED_TIMES[k]));

        for (phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 30 : (phase == 1) ? 80 : 0;
            repeat (PHASE_ITEMS)
                send_time(random_time());
        end
        start <= 1'b0;

        // drain the pipeline, then wait past the pipeline latency for stray strobes
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (ETC_LATENCY + 8)
            @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
